[design/asd_pkg.sv]
// shared types, constants and the block pair table of the superframe deinterleaver
package asd_pkg;

  // store size default, handed to the top level parameter
  localparam int BUFFER_BYTES_DEF = 16384;
  // entries of the queue between front and back
  localparam int QUEUE_DEPTH      = 4;
  // address field of a queue entry, wide enough for the largest store
  localparam int ENTRY_AW         = 16;

  // interleave modes
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_INT4  = 2'd1;
  localparam logic [1:0] MODE_SIPR  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_ACCEPT = 2'd0;
  localparam logic [1:0] ST_BYTE   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_ROWS   = 3'd1;
  localparam logic [2:0] REG_FRAME  = 3'd2;
  localparam logic [2:0] REG_CODED  = 3'd3;
  localparam logic [2:0] REG_PACKET = 3'd4;

  // sipr nibble blocks; block size is bytes/48, taken as (bytes >> 4) / 3
  localparam logic [6:0]  SIPR_BLOCKS = 7'd96;
  // divide by three as a multiply by ceil(2^17/3) and a shift, exact below 2^17
  localparam logic [16:0] DIV3_RECIP  = 17'd43691;
  localparam int          DIV3_SHIFT  = 17;

  // nibble masks
  localparam logic [7:0] NIB_LO_MASK = 8'h0F;
  localparam logic [7:0] NIB_HI_MASK = 8'hF0;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // operations handed from front to back
  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_WRITE,
    OP_STATUS,
    OP_READ,
    OP_NIB_LO,
    OP_NIB_HI
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [ENTRY_AW-1:0] addr;
    logic [7:0]          data;
    logic                sel;
    logic [1:0]          status;
    logic                key;
    logic                pend;
    logic                send;
  } qentry_t;

  // front sequencer states
  typedef enum logic [1:0] {
    FS_CLEAR,
    FS_DERIVE,
    FS_IDLE,
    FS_SIPR2
  } fstate_t;

  // sipr block exchange partner, block itself when unpaired
  function automatic logic [6:0] sipr_partner(input logic [6:0] b);
    logic [6:0] p;
    p = b;
    case (b)
      7'd0:  p = 7'd63;  7'd63: p = 7'd0;
      7'd1:  p = 7'd22;  7'd22: p = 7'd1;
      7'd2:  p = 7'd44;  7'd44: p = 7'd2;
      7'd3:  p = 7'd90;  7'd90: p = 7'd3;
      7'd5:  p = 7'd81;  7'd81: p = 7'd5;
      7'd7:  p = 7'd31;  7'd31: p = 7'd7;
      7'd8:  p = 7'd86;  7'd86: p = 7'd8;
      7'd9:  p = 7'd58;  7'd58: p = 7'd9;
      7'd10: p = 7'd36;  7'd36: p = 7'd10;
      7'd12: p = 7'd68;  7'd68: p = 7'd12;
      7'd13: p = 7'd39;  7'd39: p = 7'd13;
      7'd14: p = 7'd73;  7'd73: p = 7'd14;
      7'd15: p = 7'd53;  7'd53: p = 7'd15;
      7'd16: p = 7'd69;  7'd69: p = 7'd16;
      7'd17: p = 7'd57;  7'd57: p = 7'd17;
      7'd19: p = 7'd88;  7'd88: p = 7'd19;
      7'd20: p = 7'd34;  7'd34: p = 7'd20;
      7'd21: p = 7'd71;  7'd71: p = 7'd21;
      7'd24: p = 7'd46;  7'd46: p = 7'd24;
      7'd25: p = 7'd94;  7'd94: p = 7'd25;
      7'd26: p = 7'd54;  7'd54: p = 7'd26;
      7'd28: p = 7'd75;  7'd75: p = 7'd28;
      7'd29: p = 7'd50;  7'd50: p = 7'd29;
      7'd32: p = 7'd70;  7'd70: p = 7'd32;
      7'd33: p = 7'd92;  7'd92: p = 7'd33;
      7'd35: p = 7'd74;  7'd74: p = 7'd35;
      7'd38: p = 7'd85;  7'd85: p = 7'd38;
      7'd40: p = 7'd56;  7'd56: p = 7'd40;
      7'd42: p = 7'd87;  7'd87: p = 7'd42;
      7'd43: p = 7'd65;  7'd65: p = 7'd43;
      7'd45: p = 7'd59;  7'd59: p = 7'd45;
      7'd48: p = 7'd79;  7'd79: p = 7'd48;
      7'd49: p = 7'd93;  7'd93: p = 7'd49;
      7'd51: p = 7'd89;  7'd89: p = 7'd51;
      7'd55: p = 7'd95;  7'd95: p = 7'd55;
      7'd61: p = 7'd76;  7'd76: p = 7'd61;
      7'd67: p = 7'd83;  7'd83: p = 7'd67;
      7'd77: p = 7'd80;  7'd80: p = 7'd77;
      default: p = b;
    endcase
    return p;
  endfunction

endpackage

[design/asd_if.sv]
// valid/ready channel interfaces for stream items and result items
interface asd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] stream_byte;
  modport source (output valid, command, stream_byte, input ready);
  modport sink   (input valid, command, stream_byte, output ready);
endinterface

interface asd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] out_byte;
  logic       keyframe_packet;
  logic       packet_end;
  logic       superframe_end;
  modport source (output valid, status, out_byte, keyframe_packet, packet_end, superframe_end,
                  input ready);
  modport sink   (input valid, status, out_byte, keyframe_packet, packet_end, superframe_end,
                  output ready);
endinterface

[design/audio_superframe_deinterleaver.sv]
// top level of the audio superframe deinterleaver
// path: an accepted item goes through the operation queue, the store stage and the output register
// throughput: one item a cycle while the queue has room; a sipr read needs two store reads per byte
// reset: synchronous; after reset the store is zeroed one byte a cycle while the queue has room,
// then the packet total is derived by the remainder unit; no item
// is taken meanwhile; every accepted register write repeats that derivation
module audio_superframe_deinterleaver #(
  parameter int BUFFER_BYTES = asd_pkg::BUFFER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  asd_in_if.sink            in_chan,
  asd_out_if.source         out_chan,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [11:0]       cfg_data
);
  import asd_pkg::*;

  qentry_t push_entry, head;
  logic    push, pop, q_empty, q_full;

  // classification and addressing
  asd_front #(.BUFFER_BYTES(BUFFER_BYTES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_command (in_chan.command),
    .in_byte    (in_chan.stream_byte),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_push     (push),
    .q_entry    (push_entry),
    .q_full     (q_full)
  );

  // operation queue
  asd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  // store access and results
  asd_back #(.BUFFER_BYTES(BUFFER_BYTES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (head),
    .q_pop      (pop),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_status (out_chan.status),
    .out_byte   (out_chan.out_byte),
    .out_key    (out_chan.keyframe_packet),
    .out_pend   (out_chan.packet_end),
    .out_send   (out_chan.superframe_end)
  );

endmodule

[design/asd_ram.sv]
// generic single write port ram with registered read
module asd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/asd_front.sv]
// front: configuration, item classification, position counters and address generation
module asd_front #(
  parameter int BUFFER_BYTES = asd_pkg::BUFFER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  input  logic [7:0]        in_byte,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [11:0]       cfg_data,
  output logic              q_push,
  output asd_pkg::qentry_t  q_entry,
  input  logic              q_full
);
  import asd_pkg::*;

  localparam int AW  = $clog2(BUFFER_BYTES);
  localparam int PW  = $clog2(BUFFER_BYTES + 1);
  localparam int SW  = PW + 1;
  localparam int MW  = PW + 7;
  localparam int CW  = 18;
  localparam int BMW = PW + 17;

  fstate_t fs_r, fs_nxt;

  // configuration registers and derived lengths
  logic [1:0]    mode_r, mode_nxt;
  logic [5:0]    rows_r, rows_nxt;
  logic [11:0]   frame_r, frame_nxt, coded_r, coded_nxt, pkt_r, pkt_nxt;
  logic [PW-1:0] prod_r, prod_nxt, total_r, total_nxt, bs_r, bs_nxt;

  // buffer state
  logic [PW-1:0] wpos_r, wpos_nxt, rpos_r, rpos_nxt, brem_r, brem_nxt;
  logic [4:0]    crow_r, crow_nxt, ccol_r, ccol_nxt;
  logic [10:0]   coff_r, coff_nxt, pcnt_r, pcnt_nxt;
  logic [15:0]   colb_r, colb_nxt, rowb_r, rowb_nxt;
  logic [6:0]    blk_r, blk_nxt;
  logic          full_r, full_nxt;
  logic          key_r, key_nxt, pend_r, pend_nxt, send_r, send_nxt;
  logic [AW-1:0] clr_r, clr_nxt;

  // remainder unit used after reset and after configuration
  logic [PW-1:0] dvd_r, dvd_nxt;
  logic [12:0]   drem_r, drem_nxt;
  logic [4:0]    dstep_r, dstep_nxt;

  // combinational helpers
  logic           cfg_ok, cfg_apply, in_rng;
  logic [5:0]     rows_c;
  logic [11:0]    frame_c, pkt_c, dvsr;
  logic [17:0]    prod_c;
  logic [12:0]    drem_sh, drem_step;
  logic           dge, dlast, derive_start, clear_done;
  logic [BMW-1:0] bs_mul;
  logic [PW-1:0]  bs_calc;
  logic [4:0]     half;
  logic           full_eff, accept;
  logic [PW-1:0]  fill, total_eff;
  logic [CW-1:0]  i4_addr;
  logic           in_blocks;
  logic [MW-1:0]  mul;
  logic [SW-1:0]  src, nib_cur;
  logic           key_c, pend_c, send_c;
  logic           fin_pend, fin_send;

  // register write check
  always_comb begin
    rows_c  = rows_r;
    frame_c = frame_r;
    pkt_c   = pkt_r;
    in_rng  = (cfg_data >= 12'd1) &&
              (cfg_data <= ((cfg_index == REG_ROWS) ? 12'd32 : 12'd2048));
    if (cfg_index == REG_ROWS)   rows_c  = cfg_data[5:0];
    if (cfg_index == REG_FRAME)  frame_c = cfg_data;
    if (cfg_index == REG_PACKET) pkt_c   = cfg_data;
    prod_c = 18'(rows_c) * 18'(frame_c);
    priority if (cfg_index == REG_MODE) begin
      cfg_ok = cfg_data <= 12'd2;
    end else if (cfg_index <= REG_PACKET) begin
      cfg_ok = in_rng && (prod_c <= 18'(BUFFER_BYTES)) && (CW'(pkt_c) <= CW'(BUFFER_BYTES));
    end else begin
      cfg_ok = 1'b0;
    end
  end
  assign cfg_apply = cfg_we && cfg_ok;

  // remainder step, restoring, one bit a cycle
  assign dvsr      = pkt_r;
  assign drem_sh   = {drem_r[11:0], dvd_r[PW-1]};
  assign dge       = drem_sh >= {1'b0, dvsr};
  assign drem_step = dge ? drem_sh - {1'b0, dvsr} : drem_sh;
  assign dlast     = dstep_r == 5'(PW - 1);

  // sipr block size, bytes divided by 48
  assign bs_mul  = BMW'(prod_r >> 4) * BMW'(DIV3_RECIP);
  assign bs_calc = PW'(bs_mul >> DIV3_SHIFT);

  // derived buffer conditions
  assign half      = rows_r[5:1];
  assign full_eff  = full_r || ((mode_r == MODE_INT4) && (half == 5'd0));
  assign fill      = (mode_r == MODE_SIPR) ? prod_r : PW'(pkt_r);
  assign total_eff = (mode_r == MODE_PLAIN) ? PW'(pkt_r) : total_r;
  assign i4_addr   = CW'(colb_r) + CW'(rowb_r) + CW'(coff_r);
  assign clear_done = clr_r == AW'(BUFFER_BYTES - 1);
  assign accept    = in_valid && in_ready;

  // sipr source nibble of the current read half
  assign in_blocks = (bs_r != '0) && (blk_r < SIPR_BLOCKS);
  assign mul       = MW'(sipr_partner(blk_r)) * MW'(bs_r);
  assign nib_cur   = {rpos_r, fs_r == FS_SIPR2};
  assign src       = in_blocks ? SW'(mul) + SW'(brem_r) : nib_cur;

  // read flags of the current position
  assign key_c  = (mode_r != MODE_PLAIN) && (CW'(rpos_r) < CW'(pkt_r));
  assign pend_c = (12'(pcnt_r) + 12'd1) == pkt_r;
  assign send_c = (CW'(rpos_r) + CW'(1)) >= CW'(total_eff);
  assign fin_pend = (fs_r == FS_SIPR2) ? pend_r : pend_c;
  assign fin_send = (fs_r == FS_SIPR2) ? send_r : send_c;

  // next state
  always_comb begin
    fs_nxt = fs_r;
    unique case (fs_r)
      FS_CLEAR: begin
        if (!q_full && clear_done) fs_nxt = FS_DERIVE;
      end
      FS_DERIVE: begin
        if (!cfg_apply && dlast) fs_nxt = FS_IDLE;
      end
      FS_IDLE: begin
        if (cfg_apply) begin
          fs_nxt = FS_DERIVE;
        end else if (accept && in_command == CMD_READ && full_eff &&
                     total_eff != '0 && mode_r == MODE_SIPR) begin
          fs_nxt = FS_SIPR2;
        end
      end
      FS_SIPR2: begin
        if (cfg_apply) fs_nxt = FS_DERIVE;
        else if (!q_full) fs_nxt = FS_IDLE;
      end
      default: fs_nxt = FS_CLEAR;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    mode_nxt = mode_r; rows_nxt = rows_r; frame_nxt = frame_r;
    coded_nxt = coded_r; pkt_nxt = pkt_r; prod_nxt = prod_r;
    total_nxt = total_r; bs_nxt = bs_r;
    wpos_nxt = wpos_r; rpos_nxt = rpos_r; brem_nxt = brem_r; blk_nxt = blk_r;
    crow_nxt = crow_r; ccol_nxt = ccol_r; coff_nxt = coff_r; pcnt_nxt = pcnt_r;
    colb_nxt = colb_r; rowb_nxt = rowb_r; full_nxt = full_r;
    key_nxt = key_r; pend_nxt = pend_r; send_nxt = send_r;
    clr_nxt = clr_r;
    dvd_nxt = dvd_r; drem_nxt = drem_r; dstep_nxt = dstep_r;
    derive_start = 1'b0;
    in_ready = (fs_r == FS_IDLE) && !q_full;
    q_push   = 1'b0;
    q_entry  = '0;
    q_entry.op = OP_STATUS;

    unique case (fs_r)
      // zero the store one byte a cycle while the queue has room
      FS_CLEAR: begin
        if (!q_full) begin
          q_push       = 1'b1;
          q_entry.op   = OP_CLEAR;
          q_entry.addr = ENTRY_AW'(clr_r);
          clr_nxt      = clr_r + AW'(1);
          if (clear_done) derive_start = 1'b1;
        end
      end
      // packet total from the remainder, sipr block size by reciprocal
      FS_DERIVE: begin
        dvd_nxt   = {dvd_r[PW-2:0], 1'b0};
        drem_nxt  = drem_step;
        dstep_nxt = dstep_r + 5'd1;
        if (dlast) begin
          total_nxt = prod_r - PW'(drem_step);
          bs_nxt    = bs_calc;
        end
      end
      FS_IDLE: begin
        if (accept) begin
          if (in_command == CMD_WRITE) begin
            if (full_eff) begin
              q_push = 1'b1;
              q_entry.status = ST_REJECT;
            end else if (mode_r == MODE_INT4) begin
              // scatter write, counters walk offset, column, row
              q_push = 1'b1;
              if (i4_addr < CW'(BUFFER_BYTES)) begin
                q_entry.op   = OP_WRITE;
                q_entry.addr = ENTRY_AW'(i4_addr);
                q_entry.data = in_byte;
              end else begin
                q_entry.status = ST_ACCEPT;
              end
              coff_nxt = coff_r + 11'd1;
              if ((12'(coff_r) + 12'd1) >= coded_r) begin
                coff_nxt = '0;
                ccol_nxt = ccol_r + 5'd1;
                colb_nxt = colb_r + {3'b0, frame_r, 1'b0};
                if ((ccol_r + 5'd1) >= half) begin
                  ccol_nxt = '0;
                  colb_nxt = '0;
                  crow_nxt = crow_r + 5'd1;
                  rowb_nxt = rowb_r + {4'b0, coded_r};
                  if ((6'(crow_r) + 6'd1) >= rows_r) begin
                    crow_nxt = '0;
                    rowb_nxt = '0;
                    full_nxt = 1'b1;
                  end
                end
              end
            end else begin
              q_push       = 1'b1;
              q_entry.op   = OP_WRITE;
              q_entry.addr = ENTRY_AW'(wpos_r);
              q_entry.data = in_byte;
              wpos_nxt     = wpos_r + PW'(1);
              if ((CW'(wpos_r) + CW'(1)) >= CW'(fill)) full_nxt = 1'b1;
            end
          end else begin
            q_push = 1'b1;
            if (!full_eff) begin
              q_entry.status = ST_EMPTY;
            end else if (total_eff == '0) begin
              q_entry.status = ST_EMPTY;
              wpos_nxt = '0; rpos_nxt = '0; crow_nxt = '0; ccol_nxt = '0;
              coff_nxt = '0; colb_nxt = '0; rowb_nxt = '0; full_nxt = 1'b0;
              pcnt_nxt = '0; blk_nxt = '0; brem_nxt = '0;
            end else if (mode_r == MODE_SIPR) begin
              // low nibble now, high nibble in the next state
              q_entry.op   = OP_NIB_LO;
              q_entry.addr = ENTRY_AW'(src[SW-1:1]);
              q_entry.sel  = src[0];
              key_nxt  = key_c;
              pend_nxt = pend_c;
              send_nxt = send_c;
              if (in_blocks) begin
                if ((CW'(brem_r) + CW'(1)) >= CW'(bs_r)) begin
                  brem_nxt = '0;
                  blk_nxt  = blk_r + 7'd1;
                end else begin
                  brem_nxt = brem_r + PW'(1);
                end
              end
            end else begin
              q_entry.op   = OP_READ;
              q_entry.addr = ENTRY_AW'(rpos_r);
              q_entry.key  = key_c;
              q_entry.pend = pend_c;
              q_entry.send = send_c;
              rpos_nxt = rpos_r + PW'(1);
              pcnt_nxt = fin_pend ? '0 : pcnt_r + 11'd1;
              if (fin_send) begin
                wpos_nxt = '0; rpos_nxt = '0; crow_nxt = '0; ccol_nxt = '0;
                coff_nxt = '0; colb_nxt = '0; rowb_nxt = '0; full_nxt = 1'b0;
                pcnt_nxt = '0; blk_nxt = '0; brem_nxt = '0;
              end
            end
          end
        end
      end
      FS_SIPR2: begin
        if (!q_full) begin
          q_push       = 1'b1;
          q_entry.op   = OP_NIB_HI;
          q_entry.addr = ENTRY_AW'(src[SW-1:1]);
          q_entry.sel  = src[0];
          q_entry.key  = key_r;
          q_entry.pend = pend_r;
          q_entry.send = send_r;
          if (in_blocks) begin
            if ((CW'(brem_r) + CW'(1)) >= CW'(bs_r)) begin
              brem_nxt = '0;
              blk_nxt  = blk_r + 7'd1;
            end else begin
              brem_nxt = brem_r + PW'(1);
            end
          end
          rpos_nxt = rpos_r + PW'(1);
          pcnt_nxt = fin_pend ? '0 : pcnt_r + 11'd1;
          if (fin_send) begin
            wpos_nxt = '0; rpos_nxt = '0; crow_nxt = '0; ccol_nxt = '0;
            coff_nxt = '0; colb_nxt = '0; rowb_nxt = '0; full_nxt = 1'b0;
            pcnt_nxt = '0; blk_nxt = '0; brem_nxt = '0;
          end
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase

    // accepted register write empties the buffer
    if (cfg_apply) begin
      unique case (cfg_index)
        REG_MODE:   mode_nxt  = cfg_data[1:0];
        REG_ROWS:   rows_nxt  = cfg_data[5:0];
        REG_FRAME:  frame_nxt = cfg_data;
        REG_CODED:  coded_nxt = cfg_data;
        default:    pkt_nxt   = cfg_data;
      endcase
      prod_nxt = PW'(prod_c);
      wpos_nxt = '0; rpos_nxt = '0; crow_nxt = '0; ccol_nxt = '0;
      coff_nxt = '0; colb_nxt = '0; rowb_nxt = '0; full_nxt = 1'b0;
      pcnt_nxt = '0; blk_nxt = '0; brem_nxt = '0;
      if (fs_r != FS_CLEAR) derive_start = 1'b1;
    end

    // remainder unit load
    if (derive_start) begin
      dvd_nxt   = cfg_apply ? PW'(prod_c) : prod_r;
      drem_nxt  = '0;
      dstep_nxt = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r    <= FS_CLEAR;
      mode_r  <= MODE_PLAIN;
      rows_r  <= 6'd6;
      frame_r <= 12'd240;
      coded_r <= 12'd20;
      pkt_r   <= 12'd20;
      prod_r  <= PW'(1440);
      total_r <= '0;
      bs_r    <= '0;
      wpos_r  <= '0;
      rpos_r  <= '0;
      brem_r  <= '0;
      blk_r   <= '0;
      crow_r  <= '0;
      ccol_r  <= '0;
      coff_r  <= '0;
      pcnt_r  <= '0;
      colb_r  <= '0;
      rowb_r  <= '0;
      full_r  <= 1'b0;
      clr_r   <= '0;
      dstep_r <= '0;
    end else begin
      fs_r    <= fs_nxt;
      mode_r  <= mode_nxt;
      rows_r  <= rows_nxt;
      frame_r <= frame_nxt;
      coded_r <= coded_nxt;
      pkt_r   <= pkt_nxt;
      prod_r  <= prod_nxt;
      total_r <= total_nxt;
      bs_r    <= bs_nxt;
      wpos_r  <= wpos_nxt;
      rpos_r  <= rpos_nxt;
      brem_r  <= brem_nxt;
      blk_r   <= blk_nxt;
      crow_r  <= crow_nxt;
      ccol_r  <= ccol_nxt;
      coff_r  <= coff_nxt;
      pcnt_r  <= pcnt_nxt;
      colb_r  <= colb_nxt;
      rowb_r  <= rowb_nxt;
      full_r  <= full_nxt;
      clr_r   <= clr_nxt;
      dstep_r <= dstep_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    pend_r <= pend_nxt;
    send_r <= send_nxt;
    dvd_r  <= dvd_nxt;
    drem_r <= drem_nxt;
  end

  // an accepted item always finds room in the queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !q_full) else $error("item accepted with queue full");

  // a filled int4 superframe leaves its chunk counters at the start
  a_int4_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (full_r && mode_r == MODE_INT4) |-> (crow_r == '0 && ccol_r == '0 && coff_r == '0))
    else $error("int4 chunk counters not wrapped when full");

  // second nibble only in sipr mode
  a_sipr_only: assert property (@(posedge clk) disable iff (!rst_n)
    (fs_r == FS_SIPR2) |-> (mode_r == MODE_SIPR)) else $error("sipr step outside sipr mode");

  // reading has started only on a full buffer
  a_read_full: assert property (@(posedge clk) disable iff (!rst_n)
    (rpos_r != '0) |-> full_eff) else $error("read position moved on unfilled buffer");

endmodule

[design/asd_queue.sv]
// short fifo of operations between front and back
module asd_queue #(
  parameter int DEPTH = asd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  asd_pkg::qentry_t push_entry,
  input  logic             pop,
  output asd_pkg::qentry_t head,
  output logic             empty,
  output logic             full
);
  import asd_pkg::*;

  localparam int PTRW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  qentry_t         slots_r [DEPTH];
  logic [PTRW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  assign empty = cnt_r == '0;
  assign full  = cnt_r == CNTW'(DEPTH);
  assign head  = slots_r[rptr_r];

  // pointer and count update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTRW'(DEPTH - 1)) ? '0 : wptr_r + PTRW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTRW'(DEPTH - 1)) ? '0 : rptr_r + PTRW'(1);
    end
    if (push && !pop) cnt_nxt = cnt_r + CNTW'(1);
    if (pop && !push) cnt_nxt = cnt_r - CNTW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wptr_r] <= push_entry;
    end
  end

endmodule

[design/asd_back.sv]
// back: carries out store writes and reads and forms the result items
module asd_back #(
  parameter int BUFFER_BYTES = asd_pkg::BUFFER_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  asd_pkg::qentry_t q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_status,
  output logic [7:0]       out_byte,
  output logic             out_key,
  output logic             out_pend,
  output logic             out_send
);
  import asd_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);

  logic          advance;
  logic          ram_we, ram_re;
  logic [7:0]    ram_wdata, rdata;
  logic [3:0]    nib;
  logic          s1_v_r, s1_v_nxt;
  qentry_t       s1_r, s1_nxt;
  logic [3:0]    lo_r, lo_nxt;
  logic          ov_r, ov_nxt;
  logic [1:0]    ost_r, ost_nxt;
  logic [7:0]    obyte_r, obyte_nxt;
  logic          okey_r, okey_nxt, opend_r, opend_nxt, osend_r, osend_nxt;

  // stage moves when the output register is free or being taken
  assign advance = !ov_r || out_ready;
  assign q_pop   = !q_empty && advance;

  // store access for the popped operation
  assign ram_we    = q_pop && (q_head.op == OP_CLEAR || q_head.op == OP_WRITE);
  assign ram_re    = q_pop && (q_head.op == OP_READ || q_head.op == OP_NIB_LO ||
                               q_head.op == OP_NIB_HI);
  assign ram_wdata = (q_head.op == OP_CLEAR) ? 8'd0 : q_head.data;

  asd_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_head.addr[AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (q_head.addr[AW-1:0]),
    .rdata (rdata)
  );

  // nibble pick from the read byte
  assign nib = s1_r.sel ? 4'((rdata & NIB_HI_MASK) >> 4) : 4'(rdata & NIB_LO_MASK);

  // result formation
  always_comb begin
    s1_v_nxt  = s1_v_r;
    s1_nxt    = s1_r;
    lo_nxt    = lo_r;
    ov_nxt    = ov_r;
    ost_nxt   = ost_r;
    obyte_nxt = obyte_r;
    okey_nxt  = okey_r;
    opend_nxt = opend_r;
    osend_nxt = osend_r;
    if (advance) begin
      s1_v_nxt  = q_pop;
      s1_nxt    = q_head;
      ov_nxt    = 1'b0;
      ost_nxt   = ST_ACCEPT;
      obyte_nxt = 8'd0;
      okey_nxt  = 1'b0;
      opend_nxt = 1'b0;
      osend_nxt = 1'b0;
      if (s1_v_r) begin
        unique case (s1_r.op)
          OP_WRITE: begin
            ov_nxt = 1'b1;
          end
          OP_STATUS: begin
            ov_nxt  = 1'b1;
            ost_nxt = s1_r.status;
          end
          OP_READ: begin
            ov_nxt    = 1'b1;
            ost_nxt   = ST_BYTE;
            obyte_nxt = rdata;
            okey_nxt  = s1_r.key;
            opend_nxt = s1_r.pend;
            osend_nxt = s1_r.send;
          end
          OP_NIB_LO: begin
            lo_nxt = nib;
          end
          OP_NIB_HI: begin
            ov_nxt    = 1'b1;
            ost_nxt   = ST_BYTE;
            obyte_nxt = {nib, lo_r};
            okey_nxt  = s1_r.key;
            opend_nxt = s1_r.pend;
            osend_nxt = s1_r.send;
          end
          default: begin
            ov_nxt = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r    <= s1_nxt;
    lo_r    <= lo_nxt;
    ost_r   <= ost_nxt;
    obyte_r <= obyte_nxt;
    okey_r  <= okey_nxt;
    opend_r <= opend_nxt;
    osend_r <= osend_nxt;
  end

  assign out_valid  = ov_r;
  assign out_status = ost_r;
  assign out_byte   = obyte_r;
  assign out_key    = okey_r;
  assign out_pend   = opend_r;
  assign out_send   = osend_r;

  // a stalled result stage does not consume queue entries
  a_no_pop_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |-> !q_pop) else $error("queue popped while result stalled");

  // flags come only with a valid byte
  a_flags_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && (okey_r || opend_r || osend_r)) |-> (ost_r == ST_BYTE))
    else $error("packet flags on a non-byte result");

  // the store is never written and read in one cycle
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re)) else $error("store written and read together");

endmodule
